### rtl/core/ict_pkg.sv
// shared types, constants and tables of the imu complementary tilt filter
`default_nettype none

package ict_pkg;

  localparam int ANGLE_FRAC_DEF  = 8;
  localparam int CORDIC_ITER_DEF = 16;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 18;
  localparam int CX_W       = 36;
  localparam int CZ_W       = 27;
  localparam int TAB_FRAC   = 16;
  localparam int TAB_LEN    = 24;
  localparam int SQ_W       = 32;
  localparam int SQ_CELLS   = 16;
  localparam int DEN_W      = 21;
  localparam int SENS_W     = 11;
  localparam int RATE_W     = 10;
  localparam int RANGE_W    = 2;
  localparam int WGT_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [WGT_W-1:0]       WGT_ONE     = 11'd1024;
  localparam logic [RANGE_W-1:0]     RANGE_RST   = 2'd1;
  localparam logic [RATE_W-1:0]      RATE_RST    = 10'd250;
  localparam logic [WGT_W-1:0]       WGT_RST     = 11'd973;
  localparam logic signed [CZ_W-1:0] Z_HALF_TURN = 27'sd11796480;

  localparam logic TAG_ROLL  = 1'b0;
  localparam logic TAG_PITCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE  = 2'd0,
    CFG_RATE   = 2'd1,
    CFG_WEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUSY,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                   vld;
    logic                   tag;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic            vld;
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  function automatic logic signed [CZ_W-1:0] atan_entry(input int unsigned i);
    logic signed [CZ_W-1:0] v;
    case (i)
      0:       v = 27'sd2949120;
      1:       v = 27'sd1740967;
      2:       v = 27'sd919879;
      3:       v = 27'sd466945;
      4:       v = 27'sd234379;
      5:       v = 27'sd117304;
      6:       v = 27'sd58666;
      7:       v = 27'sd29335;
      8:       v = 27'sd14668;
      9:       v = 27'sd7334;
      10:      v = 27'sd3667;
      11:      v = 27'sd1833;
      12:      v = 27'sd917;
      13:      v = 27'sd458;
      14:      v = 27'sd229;
      15:      v = 27'sd115;
      16:      v = 27'sd57;
      17:      v = 27'sd29;
      18:      v = 27'sd14;
      19:      v = 27'sd7;
      20:      v = 27'sd4;
      21:      v = 27'sd2;
      22:      v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [SENS_W-1:0] sens_x10(input logic [RANGE_W-1:0] sel);
    logic [SENS_W-1:0] v;
    case (sel)
      2'd0:    v = 11'd1310;
      2'd1:    v = 11'd655;
      2'd2:    v = 11'd328;
      default: v = 11'd164;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ict_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module ict_div import ict_pkg::*; #(
  parameter int NW = 28,
  parameter int DW = DEN_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o,
  output logic               done_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### rtl/core/ict_sqrt_cell.sv
// one digit cell of the integer square root chain
`default_nettype none

module ict_sqrt_cell import ict_pkg::*; #(
  parameter int BITP = 30
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire sqrt_t cell_i,
  output sqrt_t      cell_o
);

  localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << BITP;

  sqrt_t         cell_d;
  sqrt_t         data_q;
  logic          vld_q;
  logic [SQ_W:0] trial;

  assign trial = {1'b0, cell_i.r} + BIT;

  always_comb begin
    cell_d = cell_i;
    if ({1'b0, cell_i.n} >= trial) begin
      cell_d.n = cell_i.n - trial[SQ_W-1:0];
      cell_d.r = (cell_i.r >> 1) + BIT[SQ_W-1:0];
    end else begin
      cell_d.r = cell_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= cell_d;
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

endmodule

`default_nettype wire

### rtl/core/ict_cordic_cell.sv
// one vectoring iteration of the cordic atan2 chain
`default_nettype none

module ict_cordic_cell import ict_pkg::*; #(
  parameter int                     SHIFT = 0,
  parameter logic signed [CZ_W-1:0] ANG   = '0
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cordic_t cell_i,
  output cordic_t      cell_o
);

  cordic_t cell_d;
  cordic_t data_q;
  logic    vld_q;

  always_comb begin
    cell_d = cell_i;
    if (cell_i.y >= 0) begin
      cell_d.x = cell_i.x + (cell_i.y >>> SHIFT);
      cell_d.y = cell_i.y - (cell_i.x >>> SHIFT);
      cell_d.z = cell_i.z + ANG;
    end else begin
      cell_d.x = cell_i.x - (cell_i.y >>> SHIFT);
      cell_d.y = cell_i.y + (cell_i.x >>> SHIFT);
      cell_d.z = cell_i.z - ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= cell_d;
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

endmodule

`default_nettype wire

### rtl/core/imu_complementary_tilt_filter.sv
// top level of the imu complementary tilt filter
`default_nettype none

// Takes one six-axis sample per beat and returns fused roll, pitch and yaw in
// signed fixed point (ANGLE_FRAC_BITS fraction bits of a degree, saturating at
// +-360 degrees). One sample is worked at a time: a beat is finished when both
// the pitch path, in which the 16-cell square-root chain feeds the CORDIC cell
// chain, and the three gyro dividers that run alongside it are done.
// A finished result waits in the output register while the next sample is
// accepted. Configuration writes are to be taken only while the block is idle:
// the user must keep to this, as the block itself does not enforce it.
module imu_complementary_tilt_filter import ict_pkg::*; #(
  parameter int ANGLE_FRAC_BITS   = ANGLE_FRAC_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic signed [IN_W-1:0] accel_x_i,
  input  wire logic signed [IN_W-1:0] accel_y_i,
  input  wire logic signed [IN_W-1:0] accel_z_i,
  input  wire logic signed [IN_W-1:0] gyro_x_i,
  input  wire logic signed [IN_W-1:0] gyro_y_i,
  input  wire logic signed [IN_W-1:0] gyro_z_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [OUT_W-1:0]    roll_out_o,
  output logic signed [OUT_W-1:0]    pitch_out_o,
  output logic signed [OUT_W-1:0]    yaw_out_o
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int NC = (CORDIC_ITERATIONS > TAB_LEN) ? TAB_LEN : CORDIC_ITERATIONS;
  localparam int AW = F + 10;
  localparam int GW = F + 13;
  localparam int NW = F + 20;
  localparam int PW = GW + WGT_W + 1;
  localparam int SW = PW + 1;
  localparam int RS = TAB_FRAC - F;

  localparam logic signed [AW-1:0] ANG_LIM   = AW'(360 * (2 ** F));
  localparam logic signed [GW-1:0] YAW_HALF  = GW'(180 * (2 ** F));
  localparam logic signed [GW-1:0] YAW_FULL  = GW'(360 * (2 ** F));
  localparam logic signed [SW-1:0] BLEND_RND = SW'(512);

  // configuration
  logic [RANGE_W-1:0] range_q;
  logic [RATE_W-1:0]  rate_q;
  logic [WGT_W-1:0]   wgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_RST;
      rate_q  <= RATE_RST;
      wgt_q   <= WGT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE:  range_q <= cfg_data_i[RANGE_W-1:0];
        CFG_RATE:   rate_q  <= cfg_data_i[RATE_W-1:0];
        CFG_WEIGHT: wgt_q   <= cfg_data_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  state_e state_q, state_d;
  logic   accept;
  logic   commit;
  logic   start_q;
  logic   roll_ok_q, pitch_ok_q, div_ok_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    accept     = 1'b0;
    commit     = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (roll_ok_q && pitch_ok_q && div_ok_q) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sample registers
  logic signed [IN_W-1:0] ax_q, ay_q, az_q;
  logic signed [IN_W-1:0] gyr_q [3];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= accel_x_i;
      ay_q   <= accel_y_i;
      az_q   <= accel_z_i;
      gyr_q[0] <= gyro_x_i;
      gyr_q[1] <= gyro_y_i;
      gyr_q[2] <= gyro_z_i;
    end
  end

  // squared magnitude of x and z
  logic signed [2*IN_W-1:0] sqx_full, sqz_full;
  logic [SQ_W-1:0]          sqx_q, sqz_q, sum_q;
  logic                     sq_vld_q, sum_vld_q;

  assign sqx_full = ax_q * ax_q;
  assign sqz_full = az_q * az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 1'b0;
      sq_vld_q  <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      start_q   <= accept;
      sq_vld_q  <= start_q;
      sum_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= unsigned'(sqx_full);
    sqz_q <= unsigned'(sqz_full);
    sum_q <= sqx_q + sqz_q;
  end

  // square root chain
  sqrt_t sq [SQ_CELLS+1];

  always_comb begin
    sq[0].vld = sum_vld_q;
    sq[0].n   = sum_q;
    sq[0].r   = '0;
  end

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    ict_sqrt_cell #(
      .BITP(SQ_W - 2 - 2 * k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(sq[k]),
      .cell_o(sq[k+1])
    );
  end

  // cordic feed with half-turn pre-rotation
  logic signed [IN_W:0] fx, fy, fxr, fyr;
  cordic_t              cd [NC+1];

  always_comb begin
    if (start_q) begin
      fy = -(IN_W + 1)'(ax_q);
      fx = (IN_W + 1)'(az_q);
    end else begin
      fy = (IN_W + 1)'(ay_q);
      fx = {1'b0, sq[SQ_CELLS].r[IN_W-1:0]};
    end
    cd[0].vld = start_q | sq[SQ_CELLS].vld;
    cd[0].tag = start_q ? TAG_ROLL : TAG_PITCH;
    if (fx < 0) begin
      fxr     = -fx;
      fyr     = -fy;
      cd[0].z = (fy >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
    end else begin
      fxr     = fx;
      fyr     = fy;
      cd[0].z = '0;
    end
    cd[0].x = CX_W'(fxr) <<< TAB_FRAC;
    cd[0].y = CX_W'(fyr) <<< TAB_FRAC;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    ict_cordic_cell #(
      .SHIFT(i),
      .ANG  (atan_entry(i))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(cd[i]),
      .cell_o(cd[i+1])
    );
  end

  logic signed [AW-1:0] zr;

  if (RS == 0) begin : g_zr_full
    assign zr = AW'(cd[NC].z);
  end else begin : g_zr_round
    assign zr = AW'((cd[NC].z + (CZ_W'(1) <<< (RS - 1))) >>> RS);
  end

  logic signed [AW-1:0] a_q [2];

  always_ff @(posedge clk_i) begin
    if (cd[NC].vld) begin
      if (cd[NC].tag == TAG_ROLL) begin
        a_q[0] <= zr;
      end else begin
        a_q[1] <= zr;
      end
    end
  end

  // gyro integration
  logic [RATE_W-1:0]    rate_eff;
  logic [DEN_W-1:0]     den;
  logic [NW-1:0]        num [3];
  logic [NW-1:0]        quo [3];
  logic                 done [3];
  logic signed [GW-1:0] dl [3];
  logic signed [GW-1:0] g_q [3];
  logic signed [AW-1:0] ang_q [3];

  assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign den      = sens_x10(range_q) * rate_eff;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    logic [IN_W-1:0] mag;
    logic [GW-2:0]   qm;

    assign mag    = gyr_q[g][IN_W-1] ? unsigned'(-gyr_q[g]) : unsigned'(gyr_q[g]);
    assign num[g] = ((NW'(mag) * NW'(10)) << F) + NW'(den >> 1);
    assign qm     = quo[g][GW-2:0];
    assign dl[g]  = gyr_q[g][IN_W-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

    ict_div #(
      .NW(NW),
      .DW(DEN_W)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(start_q),
      .num_i  (num[g]),
      .den_i  (den),
      .quo_o  (quo[g]),
      .done_o (done[g])
    );

    always_ff @(posedge clk_i) begin
      if (done[g]) begin
        g_q[g] <= GW'(ang_q[g]) + dl[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_ok_q  <= 1'b0;
      pitch_ok_q <= 1'b0;
      div_ok_q   <= 1'b0;
    end else if (accept) begin
      roll_ok_q  <= 1'b0;
      pitch_ok_q <= 1'b0;
      div_ok_q   <= 1'b0;
    end else begin
      if (cd[NC].vld && cd[NC].tag == TAG_ROLL) begin
        roll_ok_q <= 1'b1;
      end
      if (cd[NC].vld && cd[NC].tag == TAG_PITCH) begin
        pitch_ok_q <= 1'b1;
      end
      if (done[0]) begin
        div_ok_q <= 1'b1;
      end
    end
  end

  // blend
  logic [WGT_W-1:0]     w_eff, w_cmp;
  logic signed [PW-1:0] pg_q [2];
  logic signed [PW-1:0] pa_q [2];
  logic signed [AW-1:0] res_q [3];
  logic signed [AW-1:0] res_d [3];

  assign w_eff = (wgt_q > WGT_ONE) ? WGT_ONE : wgt_q;
  assign w_cmp = WGT_ONE - w_eff;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      for (int k = 0; k < 2; k++) begin
        pg_q[k] <= $signed({1'b0, w_eff}) * g_q[k];
        pa_q[k] <= $signed({1'b0, w_cmp}) * a_q[k];
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [GW-1:0] y;
    for (int k = 0; k < 2; k++) begin
      s = (SW'(pg_q[k]) + SW'(pa_q[k]) + BLEND_RND) >>> 10;
      if (s > SW'(ANG_LIM)) begin
        res_d[k] = ANG_LIM;
      end else if (s < -SW'(ANG_LIM)) begin
        res_d[k] = -ANG_LIM;
      end else begin
        res_d[k] = AW'(s);
      end
    end
    y = g_q[2];
    if (y > YAW_HALF) begin
      y = y - YAW_FULL;
    end else if (y < -YAW_HALF) begin
      y = y + YAW_FULL;
    end
    if (y > GW'(ANG_LIM)) begin
      res_d[2] = ANG_LIM;
    end else if (y < -GW'(ANG_LIM)) begin
      res_d[2] = -ANG_LIM;
    end else begin
      res_d[2] = AW'(y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADD) begin
      res_q <= res_d;
    end
  end

  // state angles and output register
  logic signed [OUT_W-1:0] out_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q[0]    <= '0;
      ang_q[1]    <= '0;
      ang_q[2]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        ang_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= OUT_W'(res_q[k]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_out_o  = out_q[0];
  assign pitch_out_o = out_q[1];
  assign yaw_out_o   = out_q[2];

endmodule

`default_nettype wire
